[sv/ins_sort_pkg.sv]
// Package for the insertion sorter: sizes, controller/datapath command and
// status structs, and the controller state type. No dependencies.
package ins_sort_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef struct packed {
    logic insert;    // store the incoming value in the sorted row
    logic mark_ovf;  // incoming value dropped, store full
    logic shift;     // result taken, move the row down by one
    logic clear;     // final result taken, drop the overflow mark
  } cmd_t;

  typedef struct packed {
    logic full;      // row holds LIST_DEPTH entries
    logic last_one;  // exactly one entry left
    logic empty;
  } sts_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

[sv/ins_sort_ctrl.sv]
// Insertion sorter controller: fill/drain state machine and handshakes.
// Depends on ins_sort_pkg.
module ins_sort_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tlast,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  ins_sort_pkg::sts_t   sts,
  output ins_sort_pkg::cmd_t   cmd
);

  ins_sort_pkg::state_t state_r, state_nxt;

  assign in_tready  = (state_r == ins_sort_pkg::ST_FILL);
  assign out_tvalid = (state_r == ins_sort_pkg::ST_DRAIN);

  always_comb begin
    state_nxt    = state_r;
    cmd.insert   = 1'b0;
    cmd.mark_ovf = 1'b0;
    cmd.shift    = 1'b0;
    cmd.clear    = 1'b0;
    unique case (state_r)
      ins_sort_pkg::ST_FILL: begin
        cmd.insert   = in_tvalid & ~sts.full;
        cmd.mark_ovf = in_tvalid & sts.full;
        if (in_tvalid && in_tlast) begin
          state_nxt = ins_sort_pkg::ST_DRAIN;
        end
      end
      ins_sort_pkg::ST_DRAIN: begin
        cmd.shift = out_tready;
        cmd.clear = out_tready & sts.last_one;
        if (out_tready && sts.last_one) begin
          state_nxt = ins_sort_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = ins_sort_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ins_sort_pkg::ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open at once");
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !sts.empty)
    else $error("draining an empty row");
  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("last transaction did not start output");
`endif

endmodule

[sv/ins_sort_dp.sv]
// Insertion sorter datapath: row of compare/shift cells, entry count and
// overflow mark. Depends on ins_sort_pkg.
module ins_sort_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  ins_sort_pkg::cmd_t                       cmd,
  input  logic signed [ins_sort_pkg::DATA_W-1:0]   value,
  output ins_sort_pkg::sts_t                       sts,
  output logic signed [ins_sort_pkg::DATA_W-1:0]   head,
  output logic                                     ovf
);

  logic signed [ins_sort_pkg::DATA_W-1:0] cell_r   [ins_sort_pkg::LIST_DEPTH];
  logic signed [ins_sort_pkg::DATA_W-1:0] cell_nxt [ins_sort_pkg::LIST_DEPTH];
  logic [ins_sort_pkg::LIST_DEPTH-1:0]    above;   // entry moves up (or is free)
  logic [ins_sort_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                                   ovf_r, ovf_nxt;

  // Sorted row: entries strictly greater than the new value, and the free
  // slots, form the upper part; equal values stay below, which keeps order.
  always_comb begin
    for (int i = 0; i < ins_sort_pkg::LIST_DEPTH; i++) begin
      above[i] = (ins_sort_pkg::CNT_W'(i) >= count_r) || (cell_r[i] > value);
    end
  end

  always_comb begin
    for (int i = 0; i < ins_sort_pkg::LIST_DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.insert) begin
        if (i > 0 && above[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end else if (above[i]) begin
          cell_nxt[i] = value;
        end
      end else if (cmd.shift && i < ins_sort_pkg::LIST_DEPTH - 1) begin
        cell_nxt[i] = cell_r[(i < ins_sort_pkg::LIST_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ins_sort_pkg::LIST_DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.shift) begin
      count_nxt = count_r - 1'b1;
    end
    if (cmd.mark_ovf) begin
      ovf_nxt = 1'b1;
    end else if (cmd.clear) begin
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign sts.full     = (count_r == ins_sort_pkg::CNT_W'(ins_sort_pkg::LIST_DEPTH));
  assign sts.last_one = (count_r == ins_sort_pkg::CNT_W'(1));
  assign sts.empty    = (count_r == '0);
  assign head         = cell_r[0];
  assign ovf          = ovf_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ins_sort_pkg::CNT_W'(ins_sort_pkg::LIST_DEPTH))
    else $error("entry count past depth");
  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0) && !ovf_r)
    else $error("list not cleared after final result");
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.full)
    else $error("insert into full row");
`endif

endmodule

[sv/insertion_sorter_top.sv]
// Insertion sorter, top level: a 64-entry sorted row of compare cells.
// On each input transaction every cell compares the new value with its own
// entry in parallel and the greater entries move up one place in the same
// cycle, so equal values keep arrival order. After the transaction marked
// tlast, the n stored values come out in ascending order, one per cycle
// while out_tready is high; the row shifts down toward the output cell on
// each taken result. No input is taken while a list drains. Values arriving
// once 64 are stored are dropped, and every result of that list then carries
// the overflow flag in out_tuser.
// Depends on ins_sort_pkg, ins_sort_ctrl and ins_sort_dp.
module insertion_sorter_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // is_last
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // end_of_list
  output logic        out_tuser   // [0] overflowed
);

  ins_sort_pkg::cmd_t cmd;
  ins_sort_pkg::sts_t sts;
  logic signed [ins_sort_pkg::DATA_W-1:0] head;
  logic                                   ovf;

  // sequencing: fill until tlast, then drain the row
  ins_sort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // cell row, count and overflow mark
  ins_sort_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .value (in_tdata),
    .sts   (sts),
    .head  (head),
    .ovf   (ovf)
  );

  // lowest cell is the output register; the greatest value is last out
  assign out_tdata = head;
  assign out_tlast = sts.last_one;
  assign out_tuser = ovf;

endmodule

[sim/tb_insertion_sorter_top.sv]
// Self-checking testbench for insertion_sorter_top: streams lists of signed
// values and checks every sorted result against a local stable-sort predictor.
// Depends on ins_sort_pkg and the insertion sorter RTL.
module tb_insertion_sorter_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One list element on the input channel.
  typedef struct packed {
    logic [ins_sort_pkg::DATA_W-1:0] value;
    logic                            is_last;
  } list_item_t;

  // One sorted result on the output channel.
  typedef struct packed {
    logic [ins_sort_pkg::DATA_W-1:0] sorted_value;
    logic                            end_of_list;
    logic                            overflowed;
  } sorted_result_t;

  // Receiver stall patterns, each held for a random stretch before the next is picked.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_RARE_STALL,
    RDY_ROTATE
  } ready_mode_t;

  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 20;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ins_sort_pkg::DATA_W-1:0] in_tdata = '0;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ins_sort_pkg::DATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;

  insertion_sorter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] value
    .in_tlast   (in_tlast),   // is_last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] sorted_value
    .out_tlast  (out_tlast),  // end_of_list
    .out_tuser  (out_tuser)   // [0] overflowed
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectations
  list_item_t     pending_items_q[$];
  sorted_result_t sorted_expect_q[$];
  int             items_queued   = 0;
  int             items_accepted = 0;
  int             error_count    = 0;
  bit             in_accepted    = 1'b0;  // input transaction at the last rising edge

  // Predictor state: the sorted row, its fill count and the dropped-element mark.
  logic signed [ins_sort_pkg::DATA_W-1:0] model_row[ins_sort_pkg::LIST_DEPTH];
  int                                     model_count = 0;
  bit                                     model_ovf   = 1'b0;

  // Insert one accepted element; on the last one, queue the whole row in order.
  task automatic sort_and_emit(input list_item_t it);
    logic signed [ins_sort_pkg::DATA_W-1:0] v;
    int                                     pos;
    sorted_result_t                         res;
    v = $signed(it.value);
    if (model_count < ins_sort_pkg::LIST_DEPTH) begin
      pos = model_count;
      // strictly greater entries move up, so equal values keep arrival order
      while (pos > 0 && model_row[pos-1] > v) begin
        model_row[pos] = model_row[pos-1];
        pos--;
      end
      model_row[pos] = v;
      model_count++;
    end else begin
      model_ovf = 1'b1;   // store full: element dropped
    end
    if (it.is_last) begin
      for (int k = 0; k < model_count; k++) begin
        res.sorted_value = model_row[k];
        res.end_of_list  = (k + 1 == model_count);
        res.overflowed   = model_ovf;
        sorted_expect_q.push_back(res);
      end
      model_count = 0;
      model_ovf   = 1'b0;
    end
  endtask

  // Monitor: everything is sampled at the rising edge, before the DUT updates.
  always @(posedge clk) begin : monitor
    sorted_result_t exp_res;
    in_accepted = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_accepted = 1'b1;
        sort_and_emit('{value: in_tdata, is_last: in_tlast});
        items_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (sorted_expect_q.size() == 0) begin
          $error("unexpected result transaction: sorted_value %0d", $signed(out_tdata));
          error_count++;
        end else begin
          exp_res = sorted_expect_q.pop_front();
          if (out_tdata !== exp_res.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   $signed(exp_res.sorted_value), $signed(out_tdata));
            error_count++;
          end
          if (out_tlast !== exp_res.end_of_list) begin
            $error("end_of_list: expected %0b, actual %0b", exp_res.end_of_list, out_tlast);
            error_count++;
          end
          if (out_tuser !== exp_res.overflowed) begin
            $error("overflowed: expected %0b, actual %0b", exp_res.overflowed, out_tuser);
            error_count++;
          end
        end
      end
    end
  end

  // Driver: bursts of back-to-back transactions with random gaps in between.
  // valid holds until the transaction is taken; only one assignment per edge.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin : driver
    list_item_t nxt;
    logic       nxt_valid;
    nxt_valid = in_tvalid;
    nxt       = '{value: in_tdata, is_last: in_tlast};
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_tvalid || in_accepted) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items_q.size() > 0) begin
        nxt       = pending_items_q.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // long unbroken stretches now and then, otherwise short bursts
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt.value;
    in_tlast  <= nxt.is_last;
  end

  // Receiver back-pressure on a pattern of its own.
  ready_mode_t rdy_mode  = RDY_ALWAYS;
  int          mode_left = 0;
  logic [7:0]  rdy_mask  = 8'hFF;

  always @(negedge clk) begin : receiver
    logic nxt_ready;
    if (mode_left == 0) begin
      rdy_mode  = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 80);
      rdy_mask  = 8'($urandom_range(1, 255));
    end
    mode_left--;
    case (rdy_mode)
      RDY_ALWAYS:     nxt_ready = 1'b1;
      RDY_COIN:       nxt_ready = 1'($urandom_range(0, 1));
      RDY_RARE_STALL: nxt_ready = ($urandom_range(0, 7) != 0);
      default: begin
        nxt_ready = rdy_mask[0];
        rdy_mask  = {rdy_mask[0], rdy_mask[7:1]};
      end
    endcase
    out_tready <= rst_n ? nxt_ready : 1'b0;
  end

  task automatic push_item(input logic [ins_sort_pkg::DATA_W-1:0] value,
                           input logic is_last);
    pending_items_q.push_back('{value: value, is_last: is_last});
    items_queued++;
  endtask

  // Value classes: full range, narrow band around zero (many duplicates), extremes.
  function automatic logic [ins_sort_pkg::DATA_W-1:0] pick_value(input int kind);
    logic [ins_sort_pkg::DATA_W-1:0] corner[7];
    corner = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0,
               32'h1, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
    case (kind)
      0:       return $urandom;
      1:       return $urandom_range(0, 15) - 8;
      2:       return corner[$urandom_range(0, 6)];
      default: return pick_value($urandom_range(0, 2));
    endcase
  endfunction

  task automatic push_list(input int len);
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < len; i++)
      push_item(pick_value(kind), i == len - 1);
  endtask

  initial begin : stimulus
    int rand_items;
    int len;

    // single-element list
    push_item(32'h0, 1'b1);
    // extremes in scrambled order, with a repeated value
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'h8000_0001, 1'b0);
    push_item(32'h0000_0005, 1'b0);
    push_item(32'h7FFF_FFFE, 1'b0);
    push_item(32'h0000_0005, 1'b0);
    push_item(32'hFFFF_FFFB, 1'b1);
    // all equal
    push_item(32'h0000_0003, 1'b0);
    push_item(32'h0000_0003, 1'b0);
    push_item(32'h0000_0003, 1'b1);
    // descending pair, last one goes to the bottom
    push_item(32'h0000_0002, 1'b0);
    push_item(32'h0000_0001, 1'b1);

    // exactly full, then full with the last element dropped
    push_list(ins_sort_pkg::LIST_DEPTH);
    push_list(ins_sort_pkg::LIST_DEPTH + 1);
    rand_items = 2 * ins_sort_pkg::LIST_DEPTH + 1;

    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 16);
        6, 7:             len = $urandom_range(17, 48);
        8:       len = $urandom_range(ins_sort_pkg::LIST_DEPTH - 4, ins_sort_pkg::LIST_DEPTH);
        default: len = $urandom_range(ins_sort_pkg::LIST_DEPTH + 1,
                                      ins_sort_pkg::LIST_DEPTH + 16);
      endcase
      push_list(len);
      rand_items += len;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_accepted == items_queued);
    wait (sorted_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
sv/ins_sort_pkg.sv
sv/ins_sort_ctrl.sv
sv/ins_sort_dp.sv
sv/insertion_sorter_top.sv
sim/tb_insertion_sorter_top.sv
